@@ rtl/vmrf_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// vmrf_pkg
// Shared constants, codes and structs of the legacy virtio mmio register file.
// ---------------------------------------------------------------------------
package vmrf_pkg;

    localparam int MAX_QUEUES = 4;
    localparam int QIDX_W     = $clog2(MAX_QUEUES);
    localparam int DATA_W     = 32;
    localparam int OFF_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int QCNT_W     = 3;
    localparam int SHIFT_W    = 5;

    localparam logic [DATA_W-1:0] MAGIC_WORD   = 32'h7472_6976;
    localparam logic [DATA_W-1:0] VERSION_WORD = 32'h0000_0001;
    localparam logic [DATA_W-1:0] VENDOR_WORD  = 32'h554D_4551;
    localparam logic [DATA_W-1:0] ALL_ONES     = 32'hffff_ffff;

    // access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // register offsets
    localparam logic [OFF_W-1:0] OFF_MAGIC         = 12'h000;
    localparam logic [OFF_W-1:0] OFF_VERSION       = 12'h004;
    localparam logic [OFF_W-1:0] OFF_DEVICE_ID     = 12'h008;
    localparam logic [OFF_W-1:0] OFF_VENDOR        = 12'h00c;
    localparam logic [OFF_W-1:0] OFF_DEV_FEATURES  = 12'h010;
    localparam logic [OFF_W-1:0] OFF_DEV_FEAT_SEL  = 12'h014;
    localparam logic [OFF_W-1:0] OFF_DRV_FEATURES  = 12'h020;
    localparam logic [OFF_W-1:0] OFF_DRV_FEAT_SEL  = 12'h024;
    localparam logic [OFF_W-1:0] OFF_PAGE_SIZE     = 12'h028;
    localparam logic [OFF_W-1:0] OFF_QUEUE_SEL     = 12'h030;
    localparam logic [OFF_W-1:0] OFF_QUEUE_NUM_MAX = 12'h034;
    localparam logic [OFF_W-1:0] OFF_QUEUE_NUM     = 12'h038;
    localparam logic [OFF_W-1:0] OFF_QUEUE_ALIGN   = 12'h03c;
    localparam logic [OFF_W-1:0] OFF_QUEUE_PFN     = 12'h040;
    localparam logic [OFF_W-1:0] OFF_QUEUE_READY   = 12'h044;
    localparam logic [OFF_W-1:0] OFF_QUEUE_NOTIFY  = 12'h050;
    localparam logic [OFF_W-1:0] OFF_INT_STATUS    = 12'h060;
    localparam logic [OFF_W-1:0] OFF_INT_ACK       = 12'h064;
    localparam logic [OFF_W-1:0] OFF_STATUS        = 12'h070;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PFN_SHIFT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_IDS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_SIZES = 2'd3;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_READ_WO  = 3'd1,
        ST_WRITE_RO = 3'd2,
        ST_UNKNOWN  = 3'd3,
        ST_PAST_END = 3'd4
    } t_status;

    typedef struct packed {
        logic              cmd;
        logic [OFF_W-1:0]  offset;
        logic [DATA_W-1:0] write_data;
        logic [DATA_W-1:0] isr;
    } t_access;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        t_status           access_status;
        logic              kick_valid;
        logic [1:0]        kick_queue;
    } t_result;

    typedef struct packed {
        logic [QCNT_W-1:0]                  queue_count;
        logic [SHIFT_W-1:0]                 pfn_shift;
        logic [31:0]                        device_ids;
        logic [63:0]                        queue_sizes;
        logic [QIDX_W-1:0]                  selected_queue;
        logic                               selection_valid;
        logic [7:0]                         status_byte;
        logic [MAX_QUEUES-1:0][DATA_W-1:0]  page_addr;
    } t_state;

    typedef struct packed {
        logic              sel_we;
        logic              sel_valid;
        logic [QIDX_W-1:0] sel_queue;
        logic              page_we;
        logic [DATA_W-1:0] page_data;
        logic              status_we;
        logic [7:0]        status_bits;
    } t_update;

endpackage
`default_nettype wire

@@ rtl/vmrf_access.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// vmrf_access
// Decodes one registered bus access against the current register state and
// forms its result word and the state update it causes.
// ---------------------------------------------------------------------------
module vmrf_access
    import vmrf_pkg::*;
(
    input  var t_access i_access,
    input  var t_state  i_state,
    output t_result     o_result,
    output t_update     o_update
);

    logic [QCNT_W-1:0] w_present;
    logic              w_sel;
    logic              w_past_end;
    logic              w_wd_in_range;
    logic              w_id_word;
    logic [QIDX_W-1:0] w_q;

    always_comb begin
        w_present     = (i_state.queue_count < QCNT_W'(MAX_QUEUES)) ?
                        i_state.queue_count : QCNT_W'(MAX_QUEUES);
        w_q           = i_state.selected_queue;
        w_sel         = i_state.selection_valid && ({1'b0, w_q} < (QIDX_W+1)'(MAX_QUEUES));
        w_past_end    = (i_access.offset[OFF_W-1:8] != '0);
        w_wd_in_range = (i_access.write_data < {{(DATA_W-QCNT_W){1'b0}}, w_present});
        w_id_word     = (i_access.offset == OFF_MAGIC) || (i_access.offset == OFF_VERSION)
                     || (i_access.offset == OFF_VENDOR);
    end

    always_comb begin
        o_result            = '0;
        o_result.access_status = ST_OK;
        o_update            = '0;
        o_update.sel_queue  = i_access.write_data[QIDX_W-1:0];
        o_update.sel_valid  = w_wd_in_range;
        o_update.page_data  = i_access.write_data << i_state.pfn_shift;
        o_update.status_bits = i_access.write_data[7:0];

        if (i_access.cmd == CMD_READ) begin
            if (w_past_end) begin
                o_result.access_status = ST_PAST_END;
                o_result.read_data     = ALL_ONES;
            end else begin
                case (i_access.offset)
                    OFF_MAGIC:         o_result.read_data = MAGIC_WORD;
                    OFF_VERSION:       o_result.read_data = VERSION_WORD;
                    OFF_VENDOR:        o_result.read_data = VENDOR_WORD;
                    OFF_DEV_FEATURES:  o_result.read_data = '0;
                    OFF_DEVICE_ID: begin
                        if (w_sel)
                            o_result.read_data = {24'd0, i_state.device_ids[{w_q, 3'b000} +: 8]};
                    end
                    OFF_QUEUE_NUM_MAX: begin
                        if (w_sel)
                            o_result.read_data =
                                {16'd0, i_state.queue_sizes[{w_q, 4'b0000} +: 16]};
                    end
                    OFF_QUEUE_PFN: begin
                        if (w_sel)
                            o_result.read_data = i_state.page_addr[w_q];
                    end
                    OFF_INT_STATUS: begin
                        if (w_sel)
                            o_result.read_data = i_access.isr;
                    end
                    OFF_STATUS:        o_result.read_data = {24'd0, i_state.status_byte};
                    OFF_DEV_FEAT_SEL, OFF_DRV_FEATURES, OFF_DRV_FEAT_SEL, OFF_PAGE_SIZE,
                    OFF_QUEUE_SEL, OFF_QUEUE_NUM, OFF_QUEUE_ALIGN, OFF_QUEUE_READY,
                    OFF_QUEUE_NOTIFY, OFF_INT_ACK:
                        o_result.access_status = ST_READ_WO;
                    default:
                        o_result.access_status = ST_UNKNOWN;
                endcase
            end
            // no backend: only the identification words read nonzero
            if ((i_state.queue_count == '0) && !w_id_word)
                o_result.read_data = '0;
        end else if (w_past_end) begin
            o_result.access_status = ST_PAST_END;
        end else begin
            case (i_access.offset)
                OFF_DEV_FEAT_SEL, OFF_DRV_FEATURES, OFF_DRV_FEAT_SEL, OFF_PAGE_SIZE,
                OFF_QUEUE_ALIGN, OFF_INT_ACK: ;
                OFF_QUEUE_SEL:    o_update.sel_we = 1'b1;
                OFF_QUEUE_PFN:    o_update.page_we = w_sel;
                OFF_QUEUE_NOTIFY: begin
                    o_result.kick_valid = w_wd_in_range;
                    o_result.kick_queue = w_wd_in_range ? i_access.write_data[1:0] : 2'd0;
                end
                OFF_STATUS:       o_update.status_we = 1'b1;
                OFF_MAGIC, OFF_VERSION, OFF_DEVICE_ID, OFF_VENDOR, OFF_DEV_FEATURES,
                OFF_QUEUE_NUM_MAX, OFF_INT_STATUS:
                    o_result.access_status = ST_WRITE_RO;
                default:
                    o_result.access_status = ST_UNKNOWN;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/vmrf_regs.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// vmrf_regs
// Configuration registers and transport state: queue selection, status byte
// and per-queue page addresses.
// ---------------------------------------------------------------------------
module vmrf_regs
    import vmrf_pkg::*;
(
    input  var logic                  i_clk,
    input  var logic                  i_rst_n,
    input  var logic                  i_cfg_we,
    input  var logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  var logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  var logic                  i_upd_en,
    input  var t_update               i_update,
    output t_state                    o_state
);

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_QUEUE_COUNT: n_state.queue_count = i_cfg_wdata[QCNT_W-1:0];
                CFG_PFN_SHIFT:   n_state.pfn_shift   = i_cfg_wdata[SHIFT_W-1:0];
                CFG_DEVICE_IDS:  n_state.device_ids  = i_cfg_wdata[31:0];
                CFG_QUEUE_SIZES: n_state.queue_sizes = i_cfg_wdata;
                default: ;
            endcase
        end
        if (i_upd_en) begin
            if (i_update.sel_we) begin
                // an out-of-range select keeps the old index
                n_state.selection_valid = i_update.sel_valid;
                if (i_update.sel_valid)
                    n_state.selected_queue = i_update.sel_queue;
            end
            if (i_update.page_we)
                n_state.page_addr[r_state.selected_queue] = i_update.page_data;
            if (i_update.status_we)
                n_state.status_byte = r_state.status_byte | i_update.status_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.queue_count     <= '0;
            r_state.pfn_shift       <= '0;
            r_state.device_ids      <= '0;
            r_state.queue_sizes     <= '0;
            r_state.selected_queue  <= '0;
            r_state.selection_valid <= 1'b1;
            r_state.status_byte     <= '0;
            r_state.page_addr       <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule
`default_nettype wire

@@ rtl/virtio_mmio_register_file.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// virtio_mmio_register_file
// Legacy virtio mmio transport register file on a stream interface.
// ---------------------------------------------------------------------------
// One bus access is taken per cycle unless the input side is stalled. The
// access is captured in an input register, decoded in a single pass against
// the register state, and the result is held in an output register while the
// state update lands on the same edge, so the next access already sees it.
// Back-pressure on the output stalls the input side only once both registers
// are full. Configuration writes go straight into the configuration registers
// and belong in idle periods.
module virtio_mmio_register_file
    import vmrf_pkg::*;
(
    input  var logic                  i_clk,
    input  var logic                  i_rst_n,
    input  var logic                  i_cfg_we,
    input  var logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  var logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  var logic                  s_axis_tvalid,
    output logic                      s_axis_tready,
    input  var logic [79:0]           s_axis_tdata,  // offset, write_data, backend_interrupt_status
    input  var logic                  s_axis_tuser,  // cmd
    output logic                      m_axis_tvalid,
    input  var logic                  m_axis_tready,
    output logic [39:0]               m_axis_tdata   // read_data, access_status, kick_valid,
                                                     // kick_queue
);

    logic    r_in_valid;
    t_access r_in;
    logic    r_out_valid;
    t_result r_out;

    logic    w_advance;
    logic    w_fire;
    t_state  w_state;
    t_result w_result;
    t_update w_update;

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready)
                r_in_valid <= s_axis_tvalid;
            if (w_advance)
                r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.cmd        <= s_axis_tuser;
            r_in.offset     <= s_axis_tdata[11:0];
            r_in.write_data <= s_axis_tdata[43:12];
            r_in.isr        <= s_axis_tdata[75:44];
        end
        if (w_fire)
            r_out <= w_result;
    end

    vmrf_access u_access (
        .i_access (r_in),
        .i_state  (w_state),
        .o_result (w_result),
        .o_update (w_update)
    );

    vmrf_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_upd_en    (w_fire),
        .i_update    (w_update),
        .o_state     (w_state)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.kick_queue, r_out.kick_valid,
                            r_out.access_status, r_out.read_data};

    // a kick only comes from a successful write, which returns no data
    a_kick_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kick_valid) |->
            (r_out.access_status == ST_OK && r_out.read_data == '0))
        else $error("kick with bad status or data");

    // write-only reads return zero
    a_wo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.access_status == ST_READ_WO) |-> (r_out.read_data == '0))
        else $error("write-only read returned data");

    // input side stalls only when both stages are full
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_in_valid && r_out_valid && !m_axis_tready))
        else $error("input stalled with room in the pipe");

    // status bits are only ever set, never cleared
    a_status_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((w_state.status_byte & $past(w_state.status_byte))
                            == $past(w_state.status_byte)))
        else $error("status byte lost a bit");

endmodule
`default_nettype wire
